@@ hw/rtl/lcc_pkg.sv @@
// Shared sizes and types for the LRU cache hit classifier.
package lcc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 16;
    localparam int ECHO_W      = 16;
    localparam int MISS_W      = 32;
    localparam int CFG_W       = 5;
    localparam int WAY_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (WAY_W > CFG_W) ? WAY_W : CFG_W;

    localparam logic [MISS_W-1:0] MISS_MAX = '1;

    typedef logic [KEY_BITS-1:0] key_t;

    // Control that every cell of the chain sees in the same cycle.
    typedef struct packed {
        logic advance;   // a request word is taken this cycle
        logic flush;     // way count rewritten: drop every entry
    } cell_ctrl_t;

endpackage

@@ hw/rtl/lcc_cell.sv @@
// One recency cell: holds a key and its valid bit, shifts from its upper neighbor.
module lcc_cell
    import lcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       in_use,
    input  key_t       req_key,
    input  key_t       up_key,
    input  logic       up_valid,
    input  logic       up_hit,
    output key_t       key_out,
    output logic       valid_out,
    output logic       hit_out
);

    key_t key_reg;
    key_t key_next;
    logic valid_reg;
    logic valid_next;
    logic match;
    logic shift;

    assign match = valid_reg & in_use & (key_reg == req_key);
    // Shift on a taken request unless unused or a more recent cell holds the key.
    assign shift = ctrl.advance & in_use & ~up_hit;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.flush)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            key_next   = up_key;
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_out   = key_reg;
    assign valid_out = valid_reg;
    assign hit_out   = up_hit | match;

endmodule

@@ hw/rtl/lcc_chain.sv @@
// Row of recency cells, most recent at cell 0, with the hit flag rippling down.
module lcc_chain
    import lcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [WAY_W-1:0] ways_eff,
    input  key_t             req_key,
    output logic             hit
);

    key_t link_key   [MAX_ENTRIES+1];
    logic link_valid [MAX_ENTRIES+1];
    logic link_hit   [MAX_ENTRIES+1];

    // The request itself feeds the top of the chain.
    assign link_key[0]   = req_key;
    assign link_valid[0] = 1'b1;
    assign link_hit[0]   = 1'b0;

    for (genvar j = 0; j < MAX_ENTRIES; j++)
    begin : g_cell
        logic in_use;

        assign in_use = (WAY_W'(j) < ways_eff);

        lcc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .in_use    (in_use),
            .req_key   (req_key),
            .up_key    (link_key[j]),
            .up_valid  (link_valid[j]),
            .up_hit    (link_hit[j]),
            .key_out   (link_key[j+1]),
            .valid_out (link_valid[j+1]),
            .hit_out   (link_hit[j+1])
        );
    end

    assign hit = link_hit[MAX_ENTRIES];

endmodule

@@ hw/rtl/lru_cache_hit_classifier.sv @@
// Top level of the LRU cache hit classifier: handshakes, way count, miss counter.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  request | in        | in_valid / in_stall     | req_key
//  result  | out       | out_valid / out_stall   | echo_key, was_hit, miss_total
//  config  | in        | cfg_valid / cfg_ready   | ways_in_use
//
// One word per cycle unless results stall: each request is matched and the whole
// chain shifted when taken; the result is in the output register the next cycle.
// The ripple of the hit flag down the cell chain sets the cycle length.
// Reset empties the directory, zeroes the miss count and sets the way count to 16.
// A stalled result holds in the output register; a new request is taken in the
// same cycle the waiting result leaves. Writing the way count empties the directory.
module lru_cache_hit_classifier
    import lcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_stall,
    input  key_t              req_key,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ECHO_W-1:0] echo_key,
    output logic              was_hit,
    output logic [MISS_W-1:0] miss_total,
    // configuration channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  ways_in_use
);

    logic [CFG_W-1:0]  ways_reg;
    logic [CFG_W-1:0]  ways_next;
    logic [WAY_W-1:0]  ways_eff;
    logic [CMP_W-1:0]  ways_wide;
    logic [MISS_W-1:0] miss_reg;
    logic [MISS_W-1:0] miss_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ECHO_W-1:0] echo_key_reg;
    logic [ECHO_W-1:0] echo_key_next;
    logic              was_hit_reg;
    logic              was_hit_next;
    logic              in_accept;
    logic              cfg_write;
    logic              hit;
    cell_ctrl_t        ctrl;

    // Take a request whenever the output register is empty or being drained.
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    // Clamp the way count: zero acts as one, anything above capacity as capacity.
    assign ways_wide = CMP_W'(ways_reg);
    always_comb
    begin
        if (ways_reg == '0)
        begin
            ways_eff = WAY_W'(1);
        end
        else if (ways_wide > CMP_W'(MAX_ENTRIES))
        begin
            ways_eff = WAY_W'(MAX_ENTRIES);
        end
        else
        begin
            ways_eff = WAY_W'(ways_wide);
        end
    end

    assign ctrl.advance = in_accept;
    assign ctrl.flush   = cfg_write;

    lcc_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .ways_eff (ways_eff),
        .req_key  (req_key),
        .hit      (hit)
    );

    always_comb
    begin
        ways_next      = ways_reg;
        miss_next      = miss_reg;
        out_valid_next = out_valid_reg;
        echo_key_next  = echo_key_reg;
        was_hit_next   = was_hit_reg;

        if (cfg_write)
        begin
            ways_next = ways_in_use;
        end

        // Drop the result once taken; a new word may refill it in the same cycle.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (in_accept)
        begin
            out_valid_next = 1'b1;
            echo_key_next  = ECHO_W'(req_key);
            was_hit_next   = hit;
            // Count the miss, holding at full scale.
            if (!hit && miss_reg != MISS_MAX)
            begin
                miss_next = miss_reg + MISS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_reg      <= CFG_W'(16);
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ways_reg      <= ways_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        echo_key_reg <= echo_key_next;
        was_hit_reg  <= was_hit_next;
    end

    assign out_valid  = out_valid_reg;
    assign echo_key   = echo_key_reg;
    assign was_hit    = was_hit_reg;
    // The counter always holds the total as of the latest result.
    assign miss_total = miss_reg;

endmodule

@@ hw/rtl/lcc_checker.sv @@
// Port-level checks for the LRU cache hit classifier, bound to the top level.
module lcc_checker
    import lcc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input key_t              req_key,
    input logic              out_valid,
    input logic              out_stall,
    input logic [ECHO_W-1:0] echo_key,
    input logic              was_hit,
    input logic [MISS_W-1:0] miss_total
);

    // A taken request shows a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted request gave no result");

    // A hit leaves the miss count; a miss bumps it or it stays saturated.
    a_miss_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=>
            (was_hit && miss_total == $past(miss_total)) ||
            (!was_hit && miss_total == $past(miss_total) + MISS_W'(1)) ||
            (!was_hit && $past(miss_total) == MISS_MAX && miss_total == MISS_MAX))
        else $error("miss count moved wrongly");

    // The same key taken twice in a row must hit the second time.
    a_repeat_hits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && $past(in_valid && !in_stall) && $past(rst_n) &&
        req_key == $past(req_key) |=> was_hit)
        else $error("repeated key missed");

    // A stalled result holds its key.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(echo_key))
        else $error("stalled result changed");

endmodule

bind lru_cache_hit_classifier lcc_checker u_lcc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_key    (req_key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .echo_key   (echo_key),
    .was_hit    (was_hit),
    .miss_total (miss_total)
);

@@ bench/lru_cache_hit_classifier_check.sv @@
// Checker for the LRU cache hit classifier: tracks the directory and compares every result word.
module lru_cache_hit_classifier_check
    import lcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  key_t              req_key,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [ECHO_W-1:0] echo_key,
    input  logic              was_hit,
    input  logic [MISS_W-1:0] miss_total,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_W-1:0]  ways_in_use,
    output int                fail_count,
    output int                pending,
    output int                hit_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ECHO_W-1:0] key;
        logic              hit;
        logic [MISS_W-1:0] total;
    } lookup_t;

    lookup_t           owed_results[$];
    key_t              slot_key[MAX_ENTRIES];
    logic              slot_valid[MAX_ENTRIES];
    int                slot_rank[MAX_ENTRIES];
    logic [MISS_W-1:0] misses;
    logic [CFG_W-1:0]  way_setting;
    int                errors;
    int                hits;

    function automatic void empty_directory();
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 0;
        end
    endfunction

    // Look the key up, update recency and the miss count, return the result word.
    function automatic lookup_t classify_request(key_t key);
        lookup_t res;
        int      ways;
        int      hit_slot;
        int      free_slot;
        int      oldest_slot;
        int      oldest_rank;
        int      slot;
        ways        = (way_setting == 0) ? 1 :
                      (way_setting > MAX_ENTRIES) ? MAX_ENTRIES : int'(way_setting);
        hit_slot    = -1;
        free_slot   = -1;
        oldest_slot = -1;
        oldest_rank = 0;
        for (int i = 0; i < ways; i++)
        begin
            if (slot_valid[i])
            begin
                if (slot_key[i] == key)
                    hit_slot = i;
                if (oldest_slot < 0 || slot_rank[i] > oldest_rank)
                begin
                    oldest_slot = i;
                    oldest_rank = slot_rank[i];
                end
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        if (hit_slot >= 0)
        begin
            for (int i = 0; i < ways; i++)
                if (slot_valid[i] && slot_rank[i] < slot_rank[hit_slot])
                    slot_rank[i]++;
            slot_rank[hit_slot] = 0;
        end
        else
        begin
            slot = (free_slot >= 0) ? free_slot : oldest_slot;
            slot_valid[slot] = 1'b0;
            for (int i = 0; i < ways; i++)
                if (slot_valid[i])
                    slot_rank[i]++;
            slot_key[slot]   = key;
            slot_valid[slot] = 1'b1;
            slot_rank[slot]  = 0;
            if (misses != MISS_MAX)
                misses++;
        end
        res.key   = key;
        res.hit   = (hit_slot >= 0);
        res.total = misses;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t want;
        if (!rst_n)
        begin
            empty_directory();
            misses      = '0;
            way_setting = 5'd16;
            owed_results.delete();
            errors      = 0;
            hits        = 0;
        end
        else
        begin
            // Compare first: a result word always answers an earlier request.
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] unexpected result word: key %h hit %b misses %0d",
                                 $realtime, echo_key, was_hit, miss_total);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (want.hit) hits++;
                    if (echo_key !== want.key || was_hit !== want.hit ||
                        miss_total !== want.total)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("[%0t] want %h/%b/%0d, got %h/%b/%0d",
                                     $realtime, want.key, want.hit, want.total,
                                     echo_key, was_hit, miss_total);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                way_setting = ways_in_use;
                empty_directory();
            end
            if (in_valid && !in_stall)
                owed_results.push_back(classify_request(req_key));
        end
        fail_count <= errors;
        pending    <= owed_results.size();
        hit_count  <= hits;
    end

endmodule

@@ bench/lru_cache_hit_classifier_test.sv @@
// Top of the LRU cache hit classifier bench: clock, reset, stimulus and verdict.
module lru_cache_hit_classifier_test;
    import lcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    key_t              req_key;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [ECHO_W-1:0] echo_key;
    logic              was_hit;
    logic [MISS_W-1:0] miss_total;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  ways_in_use;

    int fail_count;
    int pending;
    int hit_count;

    // Idle odds in percent for the request side and the result side.
    int idle_pct  = 0;
    int stall_pct = 0;

    // Bookkeeping for the summary and for the key pool.
    int               requests_sent = 0;
    int               way_writes    = 0;
    logic [CFG_W-1:0] way_written   = 5'd16;
    key_t             key_base      = '0;

    lru_cache_hit_classifier dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_key    (req_key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .echo_key   (echo_key),
        .was_hit    (was_hit),
        .miss_total (miss_total),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .ways_in_use(ways_in_use)
    );

    // The checker watches all three channels and reports back failures and backlog.
    lru_cache_hit_classifier_check check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_key    (req_key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .echo_key   (echo_key),
        .was_hit    (was_hit),
        .miss_total (miss_total),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .ways_in_use(ways_in_use),
        .fail_count (fail_count),
        .pending    (pending),
        .hit_count  (hit_count)
    );

    always #2 clk = ~clk;

    // Stall the result side at random, one draw per cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Guard against a hung handshake: the timeout is far beyond any correct run.
    initial
    begin
        #2_000_000;
        $display("lru_cache_hit_classifier: mismatch");
        $finish;
    end

    // Offer one request word, idling first at random, and hold it until taken.
    task automatic send_key(key_t key);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_key  <= key;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
    endtask

    // Drop valid and wait until every owed result word has left, plus a short cushion.
    // The first edge lets the backlog count catch up with the word just taken.
    task automatic settle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (pending != 0 && guard < 20000);
        repeat (4) @(posedge clk);
    endtask

    // Rewrite the way count; only called with the block idle.
    task automatic write_ways(logic [CFG_W-1:0] value);
        cfg_valid   <= 1'b1;
        ways_in_use <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        way_written = value;
        way_writes++;
    endtask

    // Mostly draw from a pool a little wider than the active ways, so hits and
    // evictions both come often; the rest are arbitrary keys.
    function automatic key_t next_key();
        int eff;
        eff = (way_written == 0) ? 1 :
              (way_written > MAX_ENTRIES) ? MAX_ENTRIES : int'(way_written);
        if ($urandom_range(99) < 80)
            return key_t'(key_base + $urandom_range(eff + 2));
        return key_t'($urandom);
    endfunction

    initial
    begin
        logic [CFG_W-1:0] pick;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        req_key     <= '0;
        cfg_valid   <= 1'b0;
        ways_in_use <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme keys at the reset way count, hits on both.
        send_key(16'h0000);
        send_key(16'hFFFF);
        send_key(16'h0000);
        send_key(16'hFFFF);
        send_key(16'hAAAA);
        send_key(16'h5555);
        settle();
        // Way count of zero behaves as a single way: every new key evicts.
        write_ways(5'd0);
        send_key(16'd7);
        send_key(16'd7);
        send_key(16'd8);
        send_key(16'd7);
        settle();
        // Two ways: the least recent entry goes, not the oldest fill.
        write_ways(5'd2);
        send_key(16'd1);
        send_key(16'd2);
        send_key(16'd1);
        send_key(16'd3);
        send_key(16'd2);
        send_key(16'd1);
        settle();
        // Way count above capacity clamps to the full directory; old keys are gone.
        write_ways(5'd31);
        send_key(16'd1);
        send_key(16'd1);
        settle();

        // Random: three idle profiles, five way settings each, 50 words per setting.
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 7;
                    stall_pct = 51;
                end
                1:
                begin
                    idle_pct  = 51;
                    stall_pct = 7;
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 5; blk++)
            begin
                case (blk)
                    0: pick = (ph == 0) ? 5'd0 : (ph == 1) ? 5'd31 : 5'd17;
                    1: pick = 5'd1;
                    2: pick = 5'd16;
                    default: pick = CFG_W'($urandom_range(1, MAX_ENTRIES));
                endcase
                write_ways(pick);
                key_base = key_t'($urandom);
                for (int n = 0; n < 50; n++)
                begin
                    send_key(next_key());
                    // Hold off mid-block until the result side has caught up.
                    if (n == 24)
                        settle();
                end
                settle();
            end
        end

        settle();
        $display("run covered %0d requests (%0d hits) across %0d way-count writes,",
                 requests_sent, hit_count, way_writes);
        $display("including counts 0, 1, 16, 17 and 31 under three idle profiles");
        if (fail_count == 0 && pending == 0)
            $display("lru_cache_hit_classifier: match");
        else
            $display("lru_cache_hit_classifier: mismatch");
        $finish;
    end

endmodule

@@ lru_cache_hit_classifier.f @@
hw/rtl/lcc_pkg.sv
hw/rtl/lcc_cell.sv
hw/rtl/lcc_chain.sv
hw/rtl/lru_cache_hit_classifier.sv
hw/rtl/lcc_checker.sv
bench/lru_cache_hit_classifier_check.sv
bench/lru_cache_hit_classifier_test.sv
